/* rtl/triangle_param_jacobian_defines.svh */
// assertion macros for the triangle parameterization jacobian block
// used by the top level only, no other dependencies
`ifndef TRIANGLE_PARAM_JACOBIAN_DEFINES_SVH
`define TRIANGLE_PARAM_JACOBIAN_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpj check failed");

// next-cycle implication, checked out of reset
`define TPJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpj check failed");

`endif

/* rtl/tpj_pkg.sv */
// shared widths and pipeline types for the triangle parameterization jacobian
// no dependencies
package tpj_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int FW    = 16;            // fraction bits
    localparam int DW    = CW + 1;        // corner difference
    localparam int AW    = 2 * DW;        // area product
    localparam int PW    = CW + DW;       // numerator product
    localparam int SW    = AW + 1;        // signed sums and magnitudes
    localparam int NW    = SW + FW + 1;   // scaled dividend
    localparam int DDW   = SW + 1;        // divisor, twice the area
    localparam int QW    = CW + 1;        // quotient bits kept
    localparam int NLANE = 4;

    typedef struct packed {
        logic [DDW-1:0] rem;
        logic [QW-1:0]  nlo;   // dividend bits still to shift in
        logic [QW-1:0]  quo;
        logic           ovf;
        logic           neg;
    } t_lane;

    typedef struct packed {
        logic                  vld;
        logic                  degen;
        logic [DDW-1:0]        den;
        t_lane [NLANE-1:0]     lane;
    } t_div;

endpackage

/* rtl/tpj_front.sv */
// front stages: differences, products, dot sums, magnitudes, dividend setup
// depends on tpj_pkg
module tpj_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [31:0]               i_thr,
    input  logic signed [tpj_pkg::CW-1:0] i_x_a, i_y_a, i_x_b, i_y_b, i_x_c, i_y_c,
    input  logic signed [tpj_pkg::CW-1:0] i_u_a, i_v_a, i_u_b, i_v_b, i_u_c, i_v_c,
    output tpj_pkg::t_div             o_div
);
    import tpj_pkg::*;

    // stage 1: corner differences
    logic              r_v1;
    logic signed [DW-1:0] r_wv [3], r_wu [3];
    logic signed [CW-1:0] r_x [3], r_y [3];
    // stage 2: products
    logic              r_v2;
    logic signed [AW-1:0] r_ap0, r_ap1;
    logic signed [PW-1:0] r_p [4][3];
    // stage 3: sums
    logic              r_v3;
    logic signed [SW-1:0] r_area, r_num [4];
    // stage 4: magnitudes and degenerate test
    logic              r_v4, r_dg4;
    logic [SW-1:0]     r_am, r_nm [4];
    logic [NLANE-1:0]  r_ng4;
    // stage 5: dividend setup
    t_div              r_div, n_div;
    logic [NW-1:0]     w_n [4];

    always_ff @(posedge i_clk) begin
        r_wv[0] <= DW'(i_v_b) - DW'(i_v_c);
        r_wv[1] <= DW'(i_v_c) - DW'(i_v_a);
        r_wv[2] <= DW'(i_v_a) - DW'(i_v_b);
        r_wu[0] <= DW'(i_u_c) - DW'(i_u_b);
        r_wu[1] <= DW'(i_u_a) - DW'(i_u_c);
        r_wu[2] <= DW'(i_u_b) - DW'(i_u_a);
        r_x[0] <= i_x_a; r_x[1] <= i_x_b; r_x[2] <= i_x_c;
        r_y[0] <= i_y_a; r_y[1] <= i_y_b; r_y[2] <= i_y_c;

        r_ap0 <= AW'(r_wu[2]) * AW'(r_wv[1]);
        r_ap1 <= AW'(r_wu[1]) * AW'(r_wv[2]);
        for (int k = 0; k < 3; k++) begin
            r_p[0][k] <= PW'(r_x[k]) * PW'(r_wv[k]);
            r_p[1][k] <= PW'(r_x[k]) * PW'(r_wu[k]);
            r_p[2][k] <= PW'(r_y[k]) * PW'(r_wv[k]);
            r_p[3][k] <= PW'(r_y[k]) * PW'(r_wu[k]);
        end

        r_area <= SW'(r_ap0) - SW'(r_ap1);
        for (int e = 0; e < 4; e++)
            r_num[e] <= SW'(r_p[e][0]) + SW'(r_p[e][1]) + SW'(r_p[e][2]);

        r_am  <= r_area[SW-1] ? SW'(-r_area) : SW'(r_area);
        r_dg4 <= (r_area == '0) ||
                 ((r_area[SW-1] ? SW'(-r_area) : SW'(r_area)) < SW'(i_thr));
        for (int e = 0; e < 4; e++) begin
            r_nm[e]  <= r_num[e][SW-1] ? SW'(-r_num[e]) : SW'(r_num[e]);
            r_ng4[e] <= r_num[e][SW-1];
        end

        r_div <= n_div;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // rounded quotient: (2|num|*2^fw + area) / (2*area)
    always_comb begin
        // valid cleared while in reset
        n_div.vld   = r_v4 && i_rst_n;
        n_div.degen = r_dg4;
        n_div.den   = {r_am, 1'b0};
        for (int e = 0; e < 4; e++) begin
            w_n[e] = {r_nm[e], {(FW+1){1'b0}}} + NW'(r_am);
            n_div.lane[e].rem = DDW'(w_n[e][NW-1:QW]);
            n_div.lane[e].nlo = w_n[e][QW-1:0];
            n_div.lane[e].quo = '0;
            n_div.lane[e].ovf = DDW'(w_n[e][NW-1:QW]) >= {r_am, 1'b0};
            n_div.lane[e].neg = r_ng4[e];
        end
    end

    assign o_div = r_div;

endmodule

/* rtl/tpj_div_step.sv */
// one registered restoring-division step for all four jacobian lanes
// depends on tpj_pkg
module tpj_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpj_pkg::t_div  i_div,
    output tpj_pkg::t_div  o_div
);
    import tpj_pkg::*;

    t_div             r_div, n_div;
    logic [DDW:0]     w_r2 [NLANE];

    always_comb begin
        n_div = i_div;
        // valid cleared while in reset
        n_div.vld = i_div.vld && i_rst_n;
        for (int e = 0; e < NLANE; e++) begin
            w_r2[e] = {i_div.lane[e].rem, i_div.lane[e].nlo[QW-1]};
            n_div.lane[e].nlo = {i_div.lane[e].nlo[QW-2:0], 1'b0};
            if (w_r2[e] >= {1'b0, i_div.den}) begin
                n_div.lane[e].rem = DDW'(w_r2[e] - {1'b0, i_div.den});
                n_div.lane[e].quo = {i_div.lane[e].quo[QW-2:0], 1'b1};
            end else begin
                n_div.lane[e].rem = w_r2[e][DDW-1:0];
                n_div.lane[e].quo = {i_div.lane[e].quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_div = r_div;

endmodule

/* rtl/triangle_param_jacobian.sv */
// top level: triangle parameterization jacobian, front stages, divider chain, output
// depends on tpj_pkg, tpj_front, tpj_div_step, triangle_param_jacobian_defines.svh
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------
//  input     | i_start, o_busy                | i_x_a .. i_v_c
//  result    | o_valid                        | o_dx_du .. o_dy_dv, o_degenerate
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_data (area_threshold)
//
// one item enters per cycle; o_busy stays low since nothing stalls inside
// the pipeline has 5 front stages, 33 division steps and 1 output stage
// the divider chain sets the latency, one quotient bit per stage
// reset clears all valid bits and sets the threshold to 43
`include "triangle_param_jacobian_defines.svh"
module triangle_param_jacobian (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [tpj_pkg::CW-1:0] i_x_a, i_y_a, i_x_b, i_y_b, i_x_c, i_y_c,
    input  logic signed [tpj_pkg::CW-1:0] i_u_a, i_v_a, i_u_b, i_v_b, i_u_c, i_v_c,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    output logic signed [tpj_pkg::CW-1:0] o_dx_du, o_dx_dv, o_dy_du, o_dy_dv,
    output logic                          o_degenerate
);
    import tpj_pkg::*;

    logic [31:0]        r_thr;
    t_div               w_div [QW+1];
    logic               r_vld;
    logic               r_deg;
    logic [CW-1:0]      r_ent [NLANE], n_ent [NLANE];
    logic [QW-1:0]      w_lim [NLANE], w_val [NLANE];
    logic               w_sat [NLANE];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 32'd43;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    tpj_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_start),
        .i_thr  (r_thr),
        .i_x_a(i_x_a), .i_y_a(i_y_a), .i_x_b(i_x_b),
        .i_y_b(i_y_b), .i_x_c(i_x_c), .i_y_c(i_y_c),
        .i_u_a(i_u_a), .i_v_a(i_v_a), .i_u_b(i_u_b),
        .i_v_b(i_v_b), .i_u_c(i_u_c), .i_v_c(i_v_c),
        .o_div  (w_div[0])
    );

    for (genvar s = 0; s < QW; s++) begin : g_step
        tpj_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_div  (w_div[s]),
            .o_div  (w_div[s+1])
        );
    end

    // saturate to the signed limit, then restore the sign; degenerate results give zero
    always_comb begin
        for (int e = 0; e < NLANE; e++) begin
            w_lim[e] = w_div[QW].lane[e].neg ? QW'(1) << (CW-1)
                                             : (QW'(1) << (CW-1)) - QW'(1);
            w_sat[e] = w_div[QW].lane[e].ovf || (w_div[QW].lane[e].quo > w_lim[e]);
            w_val[e] = w_sat[e] ? w_lim[e] : w_div[QW].lane[e].quo;
            if (w_div[QW].degen) begin
                n_ent[e] = '0;
            end else if (w_div[QW].lane[e].neg) begin
                n_ent[e] = CW'(-w_val[e]);
            end else begin
                n_ent[e] = CW'(w_val[e]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_deg <= w_div[QW].degen;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_div[QW].vld;
        end
    end

    assign o_valid      = r_vld;
    assign o_degenerate = r_deg;
    assign o_dx_du      = r_ent[0];
    assign o_dx_dv      = r_ent[1];
    assign o_dy_du      = r_ent[2];
    assign o_dy_dv      = r_ent[3];

    `TPJ_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate, (o_dx_du == '0) && (o_dx_dv == '0) && (o_dy_du == '0) && (o_dy_dv == '0))
    `TPJ_ASSERT_NXT(a_last_to_out, i_clk, i_rst_n, w_div[QW].vld, o_valid && (o_degenerate == $past(w_div[QW].degen)))
    `TPJ_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, !w_div[QW].vld, !o_valid)

endmodule

/* sim/triangle_param_jacobian_checker.sv */
// checker for the triangle parameterization jacobian: predicts each result and compares
// depends on tpj_pkg for the coordinate width and fraction bits; instantiated beside the block by the test top
module triangle_param_jacobian_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [tpj_pkg::CW-1:0] i_x_a, i_y_a, i_x_b, i_y_b, i_x_c, i_y_c,
    input  logic signed [tpj_pkg::CW-1:0] i_u_a, i_v_a, i_u_b, i_v_b, i_u_c, i_v_c,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    input  logic signed [tpj_pkg::CW-1:0] i_dx_du, i_dx_dv, i_dy_du, i_dy_dv,
    input  logic                          i_degenerate,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_degen_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [31:0] dx_du;
        logic signed [31:0] dx_dv;
        logic signed [31:0] dy_du;
        logic signed [31:0] dy_dv;
        logic               degenerate;
    } t_jacobian;

    t_jacobian   jacobian_q[$];
    logic [31:0] area_threshold;

    // exact quotient, rounded half away from zero, clamped to the signed range
    function automatic logic signed [31:0] rounded_ratio(t_wide num, t_wide area2);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] quo;
        logic [127:0] lim;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = ((mag << (tpj_pkg::FW + 1)) + area2) / (area2 << 1);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (quo > lim) quo = lim;
        if (neg) quo = -quo;
        return quo[31:0];
    endfunction

    function automatic t_jacobian predict_jacobian(t_wide xa, t_wide ya, t_wide xb,
            t_wide yb, t_wide xc, t_wide yc, t_wide ua, t_wide va, t_wide ub,
            t_wide vb, t_wide uc, t_wide vc, logic [31:0] thr);
        t_jacobian j;
        t_wide     area2;
        t_wide     wu0, wu1, wu2, wv0, wv1, wv2;
        area2 = (ub - ua) * (vc - va) - (uc - ua) * (vb - va);
        if (area2 < 0) area2 = -area2;
        j = '0;
        if (area2 == 0 || area2 < t_wide'({96'd0, thr})) begin
            j.degenerate = 1'b1;
            return j;
        end
        wv0 = vb - vc; wv1 = vc - va; wv2 = va - vb;
        wu0 = uc - ub; wu1 = ua - uc; wu2 = ub - ua;
        j.dx_du = rounded_ratio(xa * wv0 + xb * wv1 + xc * wv2, area2);
        j.dx_dv = rounded_ratio(xa * wu0 + xb * wu1 + xc * wu2, area2);
        j.dy_du = rounded_ratio(ya * wv0 + yb * wv1 + yc * wv2, area2);
        j.dy_dv = rounded_ratio(ya * wu0 + yb * wu1 + yc * wu2, area2);
        return j;
    endfunction

    assign o_pending = jacobian_q.size();

    always @(posedge i_clk) begin
        t_jacobian got, want;
        if (!i_rst_n) begin
            area_threshold <= 32'd43;
            o_fail_count   = 0;
            o_result_count = 0;
            o_degen_count  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) area_threshold <= i_cfg_data;
            if (i_start && !i_busy)
                jacobian_q.insert(jacobian_q.size(), predict_jacobian(i_x_a, i_y_a,
                    i_x_b, i_y_b, i_x_c, i_y_c, i_u_a, i_v_a, i_u_b, i_v_b, i_u_c,
                    i_v_c, area_threshold));
            if (i_valid) begin
                got = '{i_dx_du, i_dx_dv, i_dy_du, i_dy_dv, i_degenerate};
                o_result_count++;
                if (jacobian_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                end else begin
                    want = jacobian_q.pop_front();
                    if (want.degenerate) o_degen_count++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp %h %h %h %h dg %b got %h %h %h %h dg %b",
                                $realtime, want.dx_du, want.dx_dv, want.dy_du, want.dy_dv,
                                want.degenerate, got.dx_du, got.dx_dv, got.dy_du,
                                got.dy_dv, got.degenerate);
                    end
                end
            end
        end
    end
endmodule

/* sim/triangle_param_jacobian_test.sv */
// test top for the triangle parameterization jacobian: stimulus, config phases, verdict
// depends on tpj_pkg, triangle_param_jacobian and triangle_param_jacobian_checker
module triangle_param_jacobian_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LATENCY     = 39;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [tpj_pkg::CW-1:0] i_x_a = '0, i_y_a = '0, i_x_b = '0, i_y_b = '0;
    logic signed [tpj_pkg::CW-1:0] i_x_c = '0, i_y_c = '0, i_u_a = '0, i_v_a = '0;
    logic signed [tpj_pkg::CW-1:0] i_u_b = '0, i_v_b = '0, i_u_c = '0, i_v_c = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [tpj_pkg::CW-1:0] o_dx_du, o_dx_dv, o_dy_du, o_dy_dv;
    logic o_degenerate;

    int fail_count, pending, result_count, degen_count;
    int cycle_count = 0;
    int item_count = 0;
    bit burst_mode = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    triangle_param_jacobian u_dut (.*);

    triangle_param_jacobian_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_x_a, .i_y_a, .i_x_b, .i_y_b, .i_x_c, .i_y_c,
        .i_u_a, .i_v_a, .i_u_b, .i_v_b, .i_u_c, .i_v_c,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_valid(o_valid), .i_dx_du(o_dx_du), .i_dx_dv(o_dx_dv),
        .i_dy_du(o_dy_du), .i_dy_dv(o_dy_dv), .i_degenerate(o_degenerate),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_degen_count(degen_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_triangle(input logic signed [31:0] xa, ya, xb, yb, xc, yc,
                                 input logic signed [31:0] ua, va, ub, vb, uc, vc);
        int gap;
        i_start <= 1'b1;
        i_x_a <= xa; i_y_a <= ya; i_x_b <= xb; i_y_b <= yb; i_x_c <= xc; i_y_c <= yc;
        i_u_a <= ua; i_v_a <= va; i_u_b <= ub; i_v_b <= vb; i_u_c <= uc; i_v_c <= vc;
        do @(posedge i_clk); while (o_busy);
        item_count++;
        if (item_count % 60 == 0) burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain the pipeline before touching the threshold
    task automatic write_threshold(input logic [31:0] thr);
        if (i_start) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] spread(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
            default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        endcase
    endfunction

    task automatic random_triangle();
        int   kind;
        logic signed [31:0] xa, ya, xb, yb, xc, yc, ua, va, ub, vb, uc, vc;
        kind = $urandom_range(0, 9);
        xa = spread(kind % 3); ya = spread(kind % 3); xb = spread(kind % 3);
        yb = spread(kind % 3); xc = spread(kind % 3); yc = spread(kind % 3);
        ua = spread(kind % 3); va = spread(kind % 3); ub = spread(kind % 3);
        vb = spread(kind % 3); uc = spread(kind % 3); vc = spread(kind % 3);
        if (kind == 7) begin
            // tiny parameter triangle, doubled area near small thresholds
            ub = ua + $signed($urandom_range(0, 16)) - 8;
            vb = va + $signed($urandom_range(0, 16)) - 8;
            uc = ua + $signed($urandom_range(0, 16)) - 8;
            vc = va + $signed($urandom_range(0, 16)) - 8;
        end else if (kind == 8) begin
            // collinear parameters
            uc = ua + 2 * (ub - ua);
            vc = va + 2 * (vb - va);
        end
        send_triangle(xa, ya, xb, yb, xc, yc, ua, va, ub, vb, uc, vc);
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit right triangle, identity map
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE);
        // clockwise parameter triangle
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0);
        // all corners equal, zero area
        send_triangle(ONE, ONE, ONE, ONE, ONE, ONE, 5, 5, 5, 5, 5, 5);
        // doubled area exactly 43 and 42 around the reset threshold
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, 43, 0, 0, 1);
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, 42, 0, 0, 1);
        // tiny area with huge positions, saturates both ways
        send_triangle(MAXV, MINV, MINV, MAXV, MAXV, MINV, 0, 0, 64, 0, 0, 1);
        send_triangle(MINV, MAXV, MAXV, MINV, MINV, MAXV, 0, 0, 64, 0, 0, 1);
        // extreme parameters, largest area
        send_triangle(MAXV, MAXV, MINV, MINV, 0, 0, MINV, MINV, MAXV, MINV, MINV, MAXV);
        send_triangle(MINV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV,
                      MINV);
        // quotient of one half unit, then constant positions
        send_triangle(0, 0, 1, 0, 0, -1, 0, 0, 2, 0, 0, ONE);
        send_triangle(0, 0, -1, 0, 0, 1, 0, 0, 2, 0, 0, ONE);
        send_triangle(-1, -1, -1, -1, -1, -1, 0, 0, MAXV, 0, 0, MAXV);

        write_threshold(32'd0);
        send_triangle(ONE, ONE, ONE, ONE, ONE, ONE, 7, 7, 9, 9, 11, 11);
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, 1, 0, 0, 1);
        repeat (300) random_triangle();

        write_threshold(32'hffff_ffff);
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE);
        send_triangle(0, 0, ONE, 0, 0, ONE, 0, 0, ONE - 1, 0, 0, ONE);
        repeat (200) random_triangle();

        write_threshold($urandom_range(1, 200));
        repeat (250) random_triangle();

        write_threshold(32'd43);
        repeat (200) random_triangle();

        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d triangles sent over five threshold settings, %0d results checked",
                 item_count, result_count);
        $display("%0d of them flagged degenerate, %0d mismatches", degen_count, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/tpj_pkg.sv
rtl/tpj_front.sv
rtl/tpj_div_step.sv
rtl/triangle_param_jacobian.sv
sim/triangle_param_jacobian_checker.sv
sim/triangle_param_jacobian_test.sv
